// ----- design/bcm_pkg.sv -----
// Shared types and constants for the banked cartridge mapper.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none

package bcm_pkg;

  localparam int DEF_RAM_BANK_BYTES = 8192;
  localparam int DEF_RAM_BANKS      = 4;
  localparam int DEF_ROM_BANK_BYTES = 16384;

  typedef enum logic [2:0] {
    CMD_ROM_READ  = 3'd0,
    CMD_ROM_CTRL  = 3'd1,
    CMD_RAM_READ  = 3'd2,
    CMD_RAM_WRITE = 3'd3,
    CMD_ROM_LOAD  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_OPEN = 2'd1,
    SEL_ROM  = 2'd2,
    SEL_RAM  = 2'd3
  } sel_t;

  localparam logic [15:0] CTRL_RAM_EN_END   = 16'h2000;
  localparam logic [15:0] ROM_BANK1_BASE    = 16'h4000;
  localparam logic [15:0] CTRL_RAM_BANK_END = 16'h6000;
  localparam logic [15:0] ROM_SPACE_END     = 16'h8000;

  localparam logic [7:0] RAM_EN_KEY    = 8'h0A;
  localparam logic [7:0] OPEN_BUS_BYTE = 8'hFF;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;

endpackage

`default_nettype wire

// ----- design/bcm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; used for the ROM and RAM stores of the cartridge mapper.
`default_nettype none

module bcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/banked_cartridge_mapper.sv -----
// Banked cartridge mapper: ROM and RAM stores behind one access stream, with
// the bank control registers. Depends on bcm_pkg and bcm_ram.
//
// The block serves one bus access per transaction and takes a new one every
// cycle unless the output is stalled. Each access returns exactly one result
// in the cycle after it is taken, set by the registered read ports of the
// ROM and RAM memories; the memory read register holds the result while the
// output is stalled. Control writes and stores take effect at once for the
// next access. Both bank sizes must be powers of two. The memories need no
// clearing after reset: an unwritten byte reads back an arbitrary value.
`default_nettype none

module banked_cartridge_mapper #(
  parameter int RAM_BANK_BYTES = bcm_pkg::DEF_RAM_BANK_BYTES,
  parameter int RAM_BANKS      = bcm_pkg::DEF_RAM_BANKS,
  parameter int ROM_BANK_BYTES = bcm_pkg::DEF_ROM_BANK_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // address [15:0], write_data [23:16]
  input  wire logic [2:0]  in_tuser,   // command [2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // read_data [7:0]
  output logic             out_tuser   // open_bus [0]
);

  localparam int ROM_OFF_W = $clog2(ROM_BANK_BYTES);
  localparam int ROM_DEPTH = 2 * ROM_BANK_BYTES;
  localparam int ROM_AW    = ROM_OFF_W + 1;
  localparam int RAM_OFF_W = $clog2(RAM_BANK_BYTES);
  localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  bcm_pkg::cmd_t cmd;
  logic [15:0]   addr;
  logic [7:0]    wdata;
  logic [31:0]   addr_ext;
  logic          acc;

  logic          ram_enable_r, ram_enable_nxt;
  logic [1:0]    ram_bank_r, ram_bank_nxt;
  logic          bank_mode_r, bank_mode_nxt;
  logic          p_valid_r, p_valid_nxt;
  bcm_pkg::sel_t p_sel_r, p_sel_nxt;

  logic [1:0]    bank_mod;
  logic [1:0]    bank_sel;
  logic [31:0]   rom_idx;
  logic [31:0]   ram_idx;
  logic          rom_re, rom_we, ram_re, ram_we;
  logic [7:0]    rom_rdata, ram_rdata;

  assign cmd      = bcm_pkg::cmd_t'(in_tuser);
  assign addr     = in_tdata[15:0];
  assign wdata    = in_tdata[23:16];
  assign addr_ext = {16'b0, addr};
  assign acc      = in_tvalid && in_tready;

  assign in_tready = !p_valid_r || out_tready;

  always_comb begin
    if (RAM_BANKS == 1) begin
      bank_mod = 2'd0;
    end else if ({30'b0, ram_bank_r} >= 32'(RAM_BANKS)) begin
      bank_mod = ram_bank_r - 2'(RAM_BANKS);
    end else begin
      bank_mod = ram_bank_r;
    end
  end

  assign bank_sel = bank_mode_r ? bank_mod : 2'd0;

  assign rom_idx = ((addr >= bcm_pkg::ROM_BANK1_BASE) ? 32'(ROM_BANK_BYTES) : 32'd0)
                 + (addr_ext & 32'(ROM_BANK_BYTES - 1));
  assign ram_idx = ({30'b0, bank_sel} << RAM_OFF_W) | (addr_ext & 32'(RAM_BANK_BYTES - 1));

  assign rom_re = acc && (cmd == bcm_pkg::CMD_ROM_READ) && (addr < bcm_pkg::ROM_SPACE_END);
  assign rom_we = acc && (cmd == bcm_pkg::CMD_ROM_LOAD) && (addr_ext < 32'(ROM_DEPTH));
  assign ram_re = acc && (cmd == bcm_pkg::CMD_RAM_READ) && ram_enable_r;
  assign ram_we = acc && (cmd == bcm_pkg::CMD_RAM_WRITE) && ram_enable_r;

  bcm_ram #(
    .WIDTH (8),
    .DEPTH (ROM_DEPTH)
  ) u_rom (
    .clk   (clk),
    .we    (rom_we),
    .waddr (addr_ext[ROM_AW-1:0]),
    .wdata (wdata),
    .re    (rom_re),
    .raddr (rom_idx[ROM_AW-1:0]),
    .rdata (rom_rdata)
  );

  bcm_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_idx[RAM_AW-1:0]),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (ram_idx[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_enable_nxt = ram_enable_r;
    ram_bank_nxt   = ram_bank_r;
    bank_mode_nxt  = bank_mode_r;
    if (acc && (cmd == bcm_pkg::CMD_ROM_CTRL)) begin
      if (addr < bcm_pkg::CTRL_RAM_EN_END) begin
        ram_enable_nxt = (wdata == bcm_pkg::RAM_EN_KEY);
      end else if ((addr >= bcm_pkg::ROM_BANK1_BASE) && (addr < bcm_pkg::CTRL_RAM_BANK_END)) begin
        ram_bank_nxt = wdata[1:0];
      end else if ((addr >= bcm_pkg::CTRL_RAM_BANK_END) && (addr < bcm_pkg::ROM_SPACE_END)) begin
        bank_mode_nxt = wdata[0];
      end
    end
  end

  always_comb begin
    case (cmd)
      bcm_pkg::CMD_ROM_READ: begin
        p_sel_nxt = rom_re ? bcm_pkg::SEL_ROM : bcm_pkg::SEL_OPEN;
      end
      bcm_pkg::CMD_RAM_READ: begin
        p_sel_nxt = ram_enable_r ? bcm_pkg::SEL_RAM : bcm_pkg::SEL_OPEN;
      end
      default: begin
        p_sel_nxt = bcm_pkg::SEL_ZERO;
      end
    endcase
  end

  always_comb begin
    if (acc) begin
      p_valid_nxt = 1'b1;
    end else if (out_tready) begin
      p_valid_nxt = 1'b0;
    end else begin
      p_valid_nxt = p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r <= 1'b0;
      ram_bank_r   <= 2'd0;
      bank_mode_r  <= 1'b0;
      p_valid_r    <= 1'b0;
    end else begin
      ram_enable_r <= ram_enable_nxt;
      ram_bank_r   <= ram_bank_nxt;
      bank_mode_r  <= bank_mode_nxt;
      p_valid_r    <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_sel_r <= p_sel_nxt;
    end
  end

  always_comb begin
    case (p_sel_r)
      bcm_pkg::SEL_ROM: begin
        out_tdata = rom_rdata;
        out_tuser = 1'b0;
      end
      bcm_pkg::SEL_RAM: begin
        out_tdata = ram_rdata;
        out_tuser = 1'b0;
      end
      bcm_pkg::SEL_OPEN: begin
        out_tdata = bcm_pkg::OPEN_BUS_BYTE;
        out_tuser = 1'b1;
      end
      default: begin
        out_tdata = bcm_pkg::ZERO_BYTE;
        out_tuser = 1'b0;
      end
    endcase
  end

  assign out_tvalid = p_valid_r;

endmodule

`default_nettype wire

// ----- design/bcm_checker.sv -----
// Port-level checker for the banked cartridge mapper, bound to its top level.
// Depends on bcm_pkg for the command codes and the reply bytes.
`default_nettype none

module bcm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [23:0] in_tdata,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tuser
);

  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Every accepted access yields a result in the next cycle.
  a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("no result after an accepted access");

  // A ROM read outside ROM space is an open-bus read.
  a_rom_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == bcm_pkg::CMD_ROM_READ) && in_tdata[15]
    |=> out_tvalid && out_tuser && (out_tdata == bcm_pkg::OPEN_BUS_BYTE))
    else $error("ROM read above ROM space not flagged as open bus");

  // Accesses that are not reads return a zero byte and no open-bus flag.
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser != bcm_pkg::CMD_ROM_READ) && (in_tuser != bcm_pkg::CMD_RAM_READ)
    |=> !out_tuser && (out_tdata == bcm_pkg::ZERO_BYTE))
    else $error("non-read access returned data");

endmodule

bind banked_cartridge_mapper bcm_checker u_bcm_checker (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for banked_cartridge_mapper: directed and random bus accesses,
// with a scoreboard that predicts every reply from its own model of the bank registers.
// Depends on bcm_pkg and the design sources under design/.
`timescale 1ns / 100ps

module testbench;
  import bcm_pkg::*;

  localparam int ROM_BANK_BYTES = DEF_ROM_BANK_BYTES;
  localparam int RAM_BANK_BYTES = DEF_RAM_BANK_BYTES;
  localparam int RAM_BANKS      = DEF_RAM_BANKS;
  localparam int ROM_BYTES      = 2 * ROM_BANK_BYTES;
  localparam int RAM_BYTES      = RAM_BANKS * RAM_BANK_BYTES;

  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  localparam int TOTAL_ACCESSES = 1350;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } bus_access_t;

  typedef struct {
    logic [7:0] read_data;
    logic       open_bus;
  } bus_reply_t;

  class mapper_scoreboard;
    bus_reply_t replies_due[$];
    logic       ram_enable;
    logic [1:0] ram_bank;
    logic       bank_mode;
    logic [7:0] rom_bytes [ROM_BYTES];
    logic [7:0] ram_bytes [RAM_BYTES];
    bit         rom_loaded [ROM_BYTES];
    bit         ram_loaded [RAM_BYTES];
    int         rom_list [ROM_BYTES];
    int         rom_count;
    int         ram_list [RAM_BANKS][RAM_BANK_BYTES];
    int         ram_count [RAM_BANKS];
    int         mismatches;
    int         replies_checked;

    function new();
      ram_enable = 1'b0;
      ram_bank = 2'd0;
      bank_mode = 1'b0;
      rom_count = 0;
      mismatches = 0;
      replies_checked = 0;
      foreach (ram_count[b]) ram_count[b] = 0;
    endfunction

    function int active_bank();
      return bank_mode ? (int'(ram_bank) % RAM_BANKS) : 0;
    endfunction

    function void note_access(logic [2:0] command, logic [15:0] address,
                              logic [7:0] write_data);
      bus_reply_t reply;
      int         bank;
      int         offset;
      reply.read_data = ZERO_BYTE;
      reply.open_bus = 1'b0;
      bank = active_bank();
      offset = int'(address) % RAM_BANK_BYTES;
      case (command)
        CMD_ROM_READ: begin
          if (address < ROM_BANK1_BASE) begin
            reply.read_data = rom_bytes[int'(address) % ROM_BANK_BYTES];
          end else if (address < ROM_SPACE_END) begin
            reply.read_data = rom_bytes[ROM_BANK_BYTES + int'(address) % ROM_BANK_BYTES];
          end else begin
            reply.read_data = OPEN_BUS_BYTE;
            reply.open_bus = 1'b1;
          end
        end
        CMD_ROM_CTRL: begin
          if (address < CTRL_RAM_EN_END) begin
            ram_enable = (write_data == RAM_EN_KEY);
          end else if (address < ROM_BANK1_BASE) begin
            // The ROM bank select has no effect; bank 1 stays mapped.
          end else if (address < CTRL_RAM_BANK_END) begin
            ram_bank = write_data[1:0];
          end else if (address < ROM_SPACE_END) begin
            bank_mode = write_data[0];
          end
        end
        CMD_RAM_READ: begin
          if (ram_enable) begin
            reply.read_data = ram_bytes[bank * RAM_BANK_BYTES + offset];
          end else begin
            reply.read_data = OPEN_BUS_BYTE;
            reply.open_bus = 1'b1;
          end
        end
        CMD_RAM_WRITE: begin
          if (ram_enable) begin
            ram_bytes[bank * RAM_BANK_BYTES + offset] = write_data;
            if (!ram_loaded[bank * RAM_BANK_BYTES + offset]) begin
              ram_loaded[bank * RAM_BANK_BYTES + offset] = 1'b1;
              ram_list[bank][ram_count[bank]] = offset;
              ram_count[bank]++;
            end
          end
        end
        CMD_ROM_LOAD: begin
          if (int'(address) < ROM_BYTES) begin
            rom_bytes[address] = write_data;
            if (!rom_loaded[address]) begin
              rom_loaded[address] = 1'b1;
              rom_list[rom_count] = int'(address);
              rom_count++;
            end
          end
        end
        default: begin
        end
      endcase
      replies_due.push_back(reply);
    endfunction

    function void check_reply(logic [7:0] read_data, logic open_bus);
      bus_reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with nothing outstanding: read_data %h open_bus %b",
                 $time, read_data, open_bus);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      replies_checked++;
      if (read_data !== want.read_data) begin
        $display("%0t: read_data mismatch: expected %h, actual %h",
                 $time, want.read_data, read_data);
        mismatches++;
      end
      if (open_bus !== want.open_bus) begin
        $display("%0t: open_bus mismatch: expected %b, actual %b",
                 $time, want.open_bus, open_bus);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // address [15:0], write_data [23:16]
  logic [2:0]  in_tuser;   // command [2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // read_data [7:0]
  logic        out_tuser;  // open_bus [0]

  mapper_scoreboard sb;
  bus_access_t      directed_q[$];
  int               directed_total;
  int               idle_cycles = 0;

  always #6 clk = ~clk;

  banked_cartridge_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  task automatic random_access(output bus_access_t acc);
    int roll;
    int bank;
    int offset;
    roll = $urandom_range(0, 99);
    acc.command = CMD_ROM_READ;
    acc.address = 16'($urandom);
    acc.write_data = 8'($urandom);
    if (roll < 15) begin
      acc.command = CMD_ROM_LOAD;
      if ($urandom_range(0, 9) != 0) acc.address = 16'($urandom_range(0, ROM_BYTES - 1));
    end else if (roll < 35) begin
      acc.command = CMD_ROM_READ;
      if (sb.rom_count == 0 || $urandom_range(0, 6) == 0) begin
        acc.address = 16'($urandom_range(ROM_SPACE_END, 16'hFFFF));
      end else begin
        acc.address = 16'(sb.rom_list[$urandom_range(0, sb.rom_count - 1)]);
      end
    end else if (roll < 55) begin
      acc.command = CMD_ROM_CTRL;
      case ($urandom_range(0, 4))
        0: begin
          acc.address = 16'($urandom_range(0, CTRL_RAM_EN_END - 1));
          if ($urandom_range(0, 3) != 0) acc.write_data = RAM_EN_KEY;
        end
        1: acc.address = 16'($urandom_range(CTRL_RAM_EN_END, ROM_BANK1_BASE - 1));
        2: acc.address = 16'($urandom_range(ROM_BANK1_BASE, CTRL_RAM_BANK_END - 1));
        3: acc.address = 16'($urandom_range(CTRL_RAM_BANK_END, ROM_SPACE_END - 1));
        default: acc.address = 16'($urandom_range(ROM_SPACE_END, 16'hFFFF));
      endcase
    end else if (roll < 75) begin
      acc.command = CMD_RAM_WRITE;
    end else if (roll < 95) begin
      bank = sb.active_bank();
      if (sb.ram_enable && sb.ram_count[bank] == 0) begin
        acc.command = CMD_RAM_WRITE;
      end else begin
        acc.command = CMD_RAM_READ;
        if (sb.ram_enable) begin
          offset = sb.ram_list[bank][$urandom_range(0, sb.ram_count[bank] - 1)];
          acc.address = 16'((int'(acc.address) / RAM_BANK_BYTES) * RAM_BANK_BYTES + offset);
        end
      end
    end else begin
      acc.command = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    end
  endtask

  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int   style;
      int   run_left;
      logic level;
      style = $urandom_range(0, 2);
      run_left = 0;
      level = 1'b1;
      repeat ($urandom_range(50, 300)) begin
        @(negedge clk);
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: begin
            if (run_left == 0) begin
              level = ~level;
              run_left = level ? $urandom_range(1, 8) : $urandom_range(1, 25);
            end
            run_left--;
            out_tready <= level;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_access(in_tuser, in_tdata[15:0], in_tdata[23:16]);
      if (out_tvalid && out_tready) sb.check_reply(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    bus_access_t acc;
    int          sent;
    int          burst;
    int          gap;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;

    directed_q.push_back('{CMD_ROM_READ, 16'h8000, 8'h00});
    directed_q.push_back('{CMD_ROM_READ, 16'hFFFF, 8'hFF});
    directed_q.push_back('{CMD_RAM_READ, 16'h0000, 8'h00});
    directed_q.push_back('{CMD_RAM_WRITE, 16'hA000, 8'h99});
    directed_q.push_back('{CMD_ROM_LOAD, 16'h0000, 8'h00});
    directed_q.push_back('{CMD_ROM_LOAD, 16'h3FFF, 8'hFF});
    directed_q.push_back('{CMD_ROM_LOAD, 16'h4000, 8'hA5});
    directed_q.push_back('{CMD_ROM_LOAD, 16'h7FFF, 8'h5A});
    directed_q.push_back('{CMD_ROM_LOAD, 16'hFFFF, 8'h22});
    directed_q.push_back('{CMD_ROM_READ, 16'h0000, 8'h00});
    directed_q.push_back('{CMD_ROM_READ, 16'h3FFF, 8'h00});
    directed_q.push_back('{CMD_ROM_READ, 16'h4000, 8'h00});
    directed_q.push_back('{CMD_ROM_READ, 16'h7FFF, 8'h00});
    directed_q.push_back('{CMD_ROM_CTRL, 16'h1FFF, RAM_EN_KEY});
    directed_q.push_back('{CMD_ROM_CTRL, 16'h2000, 8'hFF});
    directed_q.push_back('{CMD_RAM_WRITE, 16'h0000, 8'h3C});
    directed_q.push_back('{CMD_RAM_WRITE, 16'hFFFF, 8'hC3});
    directed_q.push_back('{CMD_ROM_CTRL, 16'h4000, 8'hFF});
    directed_q.push_back('{CMD_ROM_CTRL, 16'h7FFF, 8'h01});
    directed_q.push_back('{CMD_RAM_WRITE, 16'hE123, 8'h77});
    directed_q.push_back('{CMD_RAM_READ, 16'h0123, 8'h00});
    directed_q.push_back('{CMD_ROM_CTRL, 16'h6000, 8'hFE});
    directed_q.push_back('{CMD_RAM_READ, 16'h2000, 8'h00});
    directed_q.push_back('{CMD_ROM_CTRL, 16'hFFFF, 8'h00});
    directed_q.push_back('{CMD_ROM_CTRL, 16'h0000, 8'h0B});
    directed_q.push_back('{CMD_RAM_READ, 16'h1FFF, 8'h00});
    directed_q.push_back('{CMD_UNUSED_LAST, 16'hFFFF, 8'hFF});
    directed_total = directed_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sent = 0;
    while (sent < TOTAL_ACCESSES) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < TOTAL_ACCESSES; i++) begin
        if (directed_q.size() != 0) acc = directed_q.pop_front();
        else random_access(acc);
        in_tvalid <= 1'b1;
        in_tdata <= {acc.write_data, acc.address};
        in_tuser <= acc.command;
        do @(posedge clk); while (!in_tready);
        @(negedge clk);
        sent++;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0 || sent >= TOTAL_ACCESSES) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end

    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bus accesses (%0d directed) over all commands and address regions.",
             sent, directed_total);
    $display("Checked %0d replies; %0d mismatches.", sb.replies_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
